@@ rtl/core/fgsc_pkg.sv @@
// shared types and constants for the four-glyph seal compositor
// no dependencies; imported by the compositor top level, its registers and its glyph store

package fgsc_pkg;

  // parameter defaults
  localparam int unsigned GLYPH_MAX_DFLT  = 32;
  localparam int unsigned COORD_BITS_DFLT = 8;

  // apb address width: eight registers at 4-byte spacing
  localparam int unsigned PADDR_W = 5;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes
  typedef enum logic [2:0] {
    REG_GLYPH_WIDTH  = 3'd0,
    REG_GLYPH_HEIGHT = 3'd1,
    REG_GAP          = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_MARGIN       = 3'd4,
    REG_FRAME_ENABLE = 3'd5,
    REG_FRAME_ROUND  = 3'd6,
    REG_LAYOUT_MODE  = 3'd7
  } reg_idx_e;

  // raw configuration registers
  typedef struct packed {
    logic [5:0] glyph_width;
    logic [5:0] glyph_height;
    logic [3:0] gap;
    logic [3:0] frame_width;
    logic [3:0] margin;
    logic       frame_enable;
    logic       frame_round;
    logic       layout_mode;
  } cfg_t;

  // seal geometry derived from the configuration
  typedef struct packed {
    logic [7:0]  side;
    logic [3:0]  frame_width;
    logic        frame_enable;
    logic        frame_round;
    logic        layout_mode;
    logic [7:0]  lo0;
    logic [7:0]  hi0_x;
    logic [7:0]  lo1_x;
    logic [7:0]  hi1_x;
    logic [7:0]  hi0_y;
    logic [7:0]  lo1_y;
    logic [7:0]  hi1_y;
    logic [6:0]  center;
    logic [15:0] outer_sq;
    logic [15:0] inner_sq;
    logic        inner_pos;
  } geom_t;

endpackage

@@ rtl/core/fgsc_glyph_mem.sv @@
// glyph row store: one write port, one registered read port
// depends on fgsc_pkg for the parameter default

module fgsc_glyph_mem import fgsc_pkg::*; #(
  parameter int unsigned GLYPH_MAX = GLYPH_MAX_DFLT
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(4*GLYPH_MAX)-1:0]   waddr_i,
  input  logic [31:0]                      wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(4*GLYPH_MAX)-1:0]   raddr_i,
  output logic [31:0]                      rdata_o
);

  localparam int unsigned DEPTH = 4 * GLYPH_MAX;

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/fgsc_regs.sv @@
// apb configuration registers and the registered seal geometry
// depends on fgsc_pkg for cfg_t, geom_t and register indexes

module fgsc_regs import fgsc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DFLT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output geom_t              geom_o
);

  localparam int unsigned SIDE_LIM = (1 << COORD_BITS) - 1;

  reg_idx_e    idx;
  cfg_t        cfg_q;
  geom_t       geom_d;
  geom_t       geom_q;
  logic [6:0]  dbl_w;
  logic [6:0]  dbl_h;
  logic [8:0]  side_raw;
  logic [7:0]  side;
  logic [4:0]  org;
  logic [7:0]  radius;
  logic [7:0]  radius_p1;
  logic signed [9:0] inner_l;
  logic [7:0]  inner_abs;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_width  <= 6'd16;
      cfg_q.glyph_height <= 6'd16;
      cfg_q.gap          <= 4'd4;
      cfg_q.frame_width  <= 4'd4;
      cfg_q.margin       <= 4'd4;
      cfg_q.frame_enable <= 1'b1;
      cfg_q.frame_round  <= 1'b0;
      cfg_q.layout_mode  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_GLYPH_WIDTH:  cfg_q.glyph_width  <= pwdata[5:0];
        REG_GLYPH_HEIGHT: cfg_q.glyph_height <= pwdata[5:0];
        REG_GAP:          cfg_q.gap          <= pwdata[3:0];
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[3:0];
        REG_MARGIN:       cfg_q.margin       <= pwdata[3:0];
        REG_FRAME_ENABLE: cfg_q.frame_enable <= pwdata[0];
        REG_FRAME_ROUND:  cfg_q.frame_round  <= pwdata[0];
        REG_LAYOUT_MODE:  cfg_q.layout_mode  <= pwdata[0];
        default:          ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (idx)
      REG_GLYPH_WIDTH:  prdata = 32'(cfg_q.glyph_width);
      REG_GLYPH_HEIGHT: prdata = 32'(cfg_q.glyph_height);
      REG_GAP:          prdata = 32'(cfg_q.gap);
      REG_FRAME_WIDTH:  prdata = 32'(cfg_q.frame_width);
      REG_MARGIN:       prdata = 32'(cfg_q.margin);
      REG_FRAME_ENABLE: prdata = 32'(cfg_q.frame_enable);
      REG_FRAME_ROUND:  prdata = 32'(cfg_q.frame_round);
      REG_LAYOUT_MODE:  prdata = 32'(cfg_q.layout_mode);
      default:          prdata = 32'd0;
    endcase
  end

  // side length with saturation
  always_comb begin
    dbl_w    = {1'b0, cfg_q.glyph_width} << 1;
    dbl_h    = {1'b0, cfg_q.glyph_height} << 1;
    side_raw = 9'((dbl_w > dbl_h) ? dbl_w : dbl_h) + 9'(cfg_q.gap)
             + {4'd0, cfg_q.margin, 1'b0}
             + (cfg_q.frame_enable ? {4'd0, cfg_q.frame_width, 1'b0} : 9'd0);
    side     = (32'(side_raw) > SIDE_LIM) ? 8'(SIDE_LIM) : side_raw[7:0];
    org      = 5'(cfg_q.margin) + (cfg_q.frame_enable ? 5'(cfg_q.frame_width) : 5'd0);
  end

  // quadrant edges and ring radii
  always_comb begin
    geom_d.side         = side;
    geom_d.frame_width  = cfg_q.frame_width;
    geom_d.frame_enable = cfg_q.frame_enable;
    geom_d.frame_round  = cfg_q.frame_round;
    geom_d.layout_mode  = cfg_q.layout_mode;
    geom_d.lo0          = 8'(org);
    geom_d.hi0_x        = 8'(org) + 8'(cfg_q.glyph_width);
    geom_d.lo1_x        = geom_d.hi0_x + 8'(cfg_q.gap);
    geom_d.hi1_x        = geom_d.lo1_x + 8'(cfg_q.glyph_width);
    geom_d.hi0_y        = 8'(org) + 8'(cfg_q.glyph_height);
    geom_d.lo1_y        = geom_d.hi0_y + 8'(cfg_q.gap);
    geom_d.hi1_y        = geom_d.lo1_y + 8'(cfg_q.glyph_height);
    geom_d.center       = side[7:1];
    radius              = {1'b0, side[7:1]} - {5'd0, cfg_q.frame_width[3:1]};
    radius_p1           = radius + 8'd1;
    inner_l             = $signed({2'b00, radius}) - $signed({6'd0, cfg_q.frame_width});
    inner_abs           = inner_l[7:0];
    geom_d.outer_sq     = 16'(radius_p1) * 16'(radius_p1);
    geom_d.inner_sq     = 16'(inner_abs) * 16'(inner_abs);
    geom_d.inner_pos    = (inner_l > 10'sd0);
  end

  // geometry follows the registers in the next cycle
  always_ff @(posedge clk_i) begin
    geom_q <= geom_d;
  end

  assign geom_o = geom_q;

endmodule

@@ rtl/core/four_glyph_seal_compositor.sv @@
// four-glyph seal compositor top level: glyph store, pixel pipeline, apb registers
// a query word's result passes the input register, the store read and the result register
// throughput: one word per cycle, loads and queries alike, while the result is not stalled
// reset: asynchronous, clears pipeline valids and sets registers to defaults; store undefined
// depends on fgsc_pkg, fgsc_regs and fgsc_glyph_mem

module four_glyph_seal_compositor import fgsc_pkg::*; #(
  parameter int unsigned GLYPH_MAX  = GLYPH_MAX_DFLT,
  parameter int unsigned COORD_BITS = COORD_BITS_DFLT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [1:0]         glyph_slot_i,
  input  logic [4:0]         glyph_row_i,
  input  logic [31:0]        row_bits_i,
  input  logic [7:0]         pixel_x_i,
  input  logic [7:0]         pixel_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               pixel_on_o,
  output logic               in_range_o,
  output logic [7:0]         seal_side_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned DEPTH = 4 * GLYPH_MAX;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [7:0]  CMASK = 8'((1 << COORD_BITS) - 1);

  typedef struct packed {
    logic        in_rng;
    logic        rect_on;
    logic        ring_on;
    logic        glyph_hit;
    logic [4:0]  col;
    logic [15:0] dx_sq;
    logic [15:0] dy_sq;
    logic [7:0]  side;
  } s2_t;

  geom_t       geom;
  logic        accept;
  logic        out_free;
  logic        s2_free;
  logic        s1_free;
  logic        s1_v_q;
  logic [7:0]  x_q;
  logic [7:0]  y_q;
  logic        s2_v_q;
  s2_t         s2_d;
  s2_t         s2_q;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [31:0] mem_rdata;
  logic        hit_x;
  logic        hit_y;
  logic        right;
  logic        bottom;
  logic [7:0]  col_full;
  logic [7:0]  row_full;
  logic [1:0]  slot;
  logic        row_ok;
  logic [8:0]  x_far;
  logic [8:0]  y_far;
  logic        rect_hit;
  logic [7:0]  adx;
  logic [7:0]  ady;
  logic [16:0] d2;
  logic        glyph_px;
  logic        pix_d;
  logic        out_v_q;
  logic        pixel_on_q;
  logic        in_range_q;
  logic [7:0]  seal_side_q;

  // configuration
  fgsc_regs #(
    .COORD_BITS (COORD_BITS)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom_o  (geom)
  );

  // stage handshake, each stage fills when it is empty or the next one frees
  assign out_free   = !out_v_q || out_ready_i;
  assign s2_free    = !s2_v_q || out_free;
  assign s1_free    = !s1_v_q || s2_free;
  assign in_ready_o = s1_free;
  assign accept     = in_valid_i && in_ready_o;

  // loads with a row below GLYPH_MAX go straight into the store
  assign mem_we    = accept && (op_i == OP_LOAD) && (32'(glyph_row_i) < GLYPH_MAX);
  assign mem_waddr = AW'(32'(glyph_slot_i) * GLYPH_MAX + 32'(glyph_row_i));

  // input register, queries only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_free) begin
      s1_v_q <= accept && (op_i == OP_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= pixel_x_i & CMASK;
      y_q <= pixel_y_i & CMASK;
    end
  end

  // quadrant decode and glyph address
  always_comb begin
    hit_x    = 1'b1;
    hit_y    = 1'b1;
    right    = 1'b0;
    bottom   = 1'b0;
    col_full = x_q - geom.lo0;
    row_full = y_q - geom.lo0;
    if (x_q >= geom.lo0 && x_q < geom.hi0_x) begin
      right    = 1'b0;
      col_full = x_q - geom.lo0;
    end else if (x_q >= geom.lo1_x && x_q < geom.hi1_x) begin
      right    = 1'b1;
      col_full = x_q - geom.lo1_x;
    end else begin
      hit_x = 1'b0;
    end
    if (y_q >= geom.lo0 && y_q < geom.hi0_y) begin
      bottom   = 1'b0;
      row_full = y_q - geom.lo0;
    end else if (y_q >= geom.lo1_y && y_q < geom.hi1_y) begin
      bottom   = 1'b1;
      row_full = y_q - geom.lo1_y;
    end else begin
      hit_y = 1'b0;
    end
    case ({right, bottom})
      2'b10:   slot = 2'd0;
      2'b01:   slot = 2'd3;
      2'b00:   slot = geom.layout_mode ? 2'd2 : 2'd1;
      default: slot = geom.layout_mode ? 2'd1 : 2'd2;
    endcase
    row_ok    = (32'(row_full) < GLYPH_MAX) && (row_full < 8'd32);
    mem_raddr = row_ok ? AW'(32'(slot) * GLYPH_MAX + 32'(row_full)) : '0;
  end

  // border tests and distances to the center
  always_comb begin
    x_far    = {1'b0, x_q} + {5'd0, geom.frame_width};
    y_far    = {1'b0, y_q} + {5'd0, geom.frame_width};
    rect_hit = (x_q < {4'd0, geom.frame_width}) || (y_q < {4'd0, geom.frame_width})
            || (x_far >= {1'b0, geom.side}) || (y_far >= {1'b0, geom.side});
    adx      = (x_q >= {1'b0, geom.center}) ? x_q - {1'b0, geom.center}
                                            : {1'b0, geom.center} - x_q;
    ady      = (y_q >= {1'b0, geom.center}) ? y_q - {1'b0, geom.center}
                                            : {1'b0, geom.center} - y_q;

    s2_d.in_rng    = (x_q < geom.side) && (y_q < geom.side);
    s2_d.ring_on   = geom.frame_enable && geom.frame_round;
    s2_d.rect_on   = geom.frame_enable && !geom.frame_round && rect_hit;
    s2_d.glyph_hit = hit_x && hit_y && row_ok && (col_full < 8'd32);
    s2_d.col       = col_full[4:0];
    s2_d.dx_sq     = 16'(adx) * 16'(adx);
    s2_d.dy_sq     = 16'(ady) * 16'(ady);
    s2_d.side      = geom.side;
  end

  // store read stage
  fgsc_glyph_mem #(
    .GLYPH_MAX (GLYPH_MAX)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (row_bits_i),
    .re_i    (s2_free && s1_v_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_v_q) begin
      s2_q <= s2_d;
    end
  end

  // pixel compose: ring clears outside, border inks, else glyph shows
  always_comb begin
    d2       = 17'(s2_q.dx_sq) + 17'(s2_q.dy_sq);
    glyph_px = s2_q.glyph_hit && mem_rdata[s2_q.col];
    if (!s2_q.in_rng) begin
      pix_d = 1'b0;
    end else if (s2_q.ring_on) begin
      if (d2 >= 17'(geom.outer_sq)) begin
        pix_d = 1'b0;
      end else if (!geom.inner_pos || d2 >= 17'(geom.inner_sq)) begin
        pix_d = 1'b1;
      end else begin
        pix_d = glyph_px;
      end
    end else if (s2_q.rect_on) begin
      pix_d = 1'b1;
    end else begin
      pix_d = glyph_px;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s2_v_q) begin
      pixel_on_q  <= pix_d;
      in_range_q  <= s2_q.in_rng;
      seal_side_q <= s2_q.side;
    end
  end

  assign out_valid_o = out_v_q;
  assign pixel_on_o  = pixel_on_q;
  assign in_range_o  = in_range_q;
  assign seal_side_o = seal_side_q;

endmodule

@@ rtl/core/fgsc_checker.sv @@
// port-level checks for the four-glyph seal compositor, bound to the top level
// no package dependency; sees only the top-level ports

module fgsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       pixel_on_o,
  input logic       in_range_o,
  input logic [7:0] seal_side_o
);

  // a result outside the seal is never ink
  a_outside_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> !pixel_on_o)
    else $error("ink reported outside the seal square");

  // an in-range pixel needs a non-empty seal
  a_side_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_range_o |-> seal_side_o != 8'd0)
    else $error("in-range pixel with zero seal side");

  // input back-pressure only comes from a stalled result
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_on_o)
      && $stable(in_range_o) && $stable(seal_side_o))
    else $error("stalled result changed");

endmodule

bind four_glyph_seal_compositor fgsc_checker u_fgsc_checker (.*);
